### design/pba_pkg.sv
// Shared types and constants for the page bitmap allocator.
// Used by pba_div and page_bitmap_allocator; no dependencies.
`default_nettype none

package pba_pkg;

  // Field widths of the ports
  localparam int PAGE_W = 17;   // page counts and page numbers inside the block
  localparam int IDX_W  = 16;   // page index on the ports
  localparam int REQ_W  = 2;
  localparam int STAT_W = 2;
  localparam int CFG_IDX_W = 1;
  localparam int BASE_W = PAGE_W + 1;  // word base may run one word past the count
  localparam int STEP_W = $clog2(PAGE_W + 1);

  // Bitmap word geometry; a power of two so word and bit split by shift and mask
  localparam int WORD_BITS = 32;
  localparam int BIT_W     = $clog2(WORD_BITS);

  // Request codes
  localparam logic [REQ_W-1:0] REQ_INIT  = 2'd0;
  localparam logic [REQ_W-1:0] REQ_ALLOC = 2'd1;
  localparam logic [REQ_W-1:0] REQ_FREE  = 2'd2;

  // Status codes
  localparam logic [STAT_W-1:0] STAT_OK    = 2'd0;
  localparam logic [STAT_W-1:0] STAT_OOM   = 2'd1;
  localparam logic [STAT_W-1:0] STAT_RANGE = 2'd2;

  // Configuration register indexes
  localparam logic [CFG_IDX_W-1:0] CFG_PAGE_COUNT = 1'd0;
  localparam logic [CFG_IDX_W-1:0] CFG_RESERVED   = 1'd1;

  typedef enum logic [3:0] {
    S_CLEAR,
    S_IDLE,
    S_INIT_RD,
    S_INIT_WR,
    S_DIV_HINT,
    S_SCAN_RD,
    S_SCAN_CHK,
    S_FREE_RD,
    S_FREE_WR,
    S_RESP
  } state_t;

  typedef struct packed {
    logic              start;
    logic [PAGE_W-1:0] dividend;
    logic [PAGE_W-1:0] divisor;
  } div_req_t;

  typedef struct packed {
    logic              done;
    logic [PAGE_W-1:0] quot;
    logic [PAGE_W-1:0] rem;
  } div_rsp_t;

endpackage

`default_nettype wire

### design/pba_div.sv
// Restoring divider, one quotient bit per cycle.
// Depends on pba_pkg for widths and the request and response structs.
`default_nettype none

module pba_div import pba_pkg::*; (
  input  wire logic     clk,
  input  wire logic     rst_n,
  input  wire div_req_t req,
  output div_rsp_t      rsp
);

  logic              busy_r, busy_nxt;
  logic              done_r, done_nxt;
  logic [STEP_W-1:0] step_r, step_nxt;
  logic [PAGE_W-1:0] q_r, q_nxt;
  logic [PAGE_W:0]   r_r, r_nxt;
  logic [PAGE_W-1:0] d_r, d_nxt;
  logic [PAGE_W:0]   trial;

  always_comb begin
    busy_nxt = busy_r;
    step_nxt = step_r;
    q_nxt    = q_r;
    r_nxt    = r_r;
    d_nxt    = d_r;
    done_nxt = 1'b0;
    trial    = {r_r[PAGE_W-1:0], q_r[PAGE_W-1]};
    if (req.start) begin
      busy_nxt = 1'b1;
      step_nxt = STEP_W'(PAGE_W);
      q_nxt    = req.dividend;
      r_nxt    = '0;
      d_nxt    = req.divisor;
    end else if (busy_r) begin
      if (trial >= {1'b0, d_r}) begin
        r_nxt = trial - {1'b0, d_r};
        q_nxt = {q_r[PAGE_W-2:0], 1'b1};
      end else begin
        r_nxt = trial;
        q_nxt = {q_r[PAGE_W-2:0], 1'b0};
      end
      step_nxt = step_r - STEP_W'(1);
      if (step_r == STEP_W'(1)) begin
        busy_nxt = 1'b0;
        done_nxt = 1'b1;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      busy_r <= 1'b0;
      done_r <= 1'b0;
      step_r <= '0;
    end else begin
      busy_r <= busy_nxt;
      done_r <= done_nxt;
      step_r <= step_nxt;
    end
    q_r <= q_nxt;
    r_r <= r_nxt;
    d_r <= d_nxt;
  end

  assign rsp.done = done_r;
  assign rsp.quot = q_r;
  assign rsp.rem  = r_r[PAGE_W-1:0];

endmodule

`default_nettype wire

### design/page_bitmap_allocator.sv
// Page frame allocator over a used-page bitmap held in one synchronous RAM of
// MAX_PAGES/WORD_BITS words; depends on pba_pkg and pba_div. One request is
// handled at a time, and the next is taken while the last result still waits.
// After reset a fill pass writes every bitmap word to all ones, with no request
// accepted. Init reads and rewrites each bitmap word up to the page count.
// Alloc runs one division (hint modulo count) in the bit-serial divider, then
// reads and checks bitmap words from the hint on until a free page is found.
// Free reads the page's word from the RAM and writes it back with the bit clear.
`default_nettype none

module page_bitmap_allocator import pba_pkg::*; #(
  parameter int MAX_PAGES = 65536
) (
  input  wire logic                 clk,
  input  wire logic                 rst_n,
  // request channel
  input  wire logic                 in_valid,
  output logic                      in_stall,
  input  wire logic [REQ_W-1:0]     in_req_type,
  input  wire logic [IDX_W-1:0]     in_page_index,
  // result channel
  output logic                      out_valid,
  input  wire logic                 out_stall,
  output logic [IDX_W-1:0]          out_page_index_out,
  output logic [STAT_W-1:0]         out_status,
  output logic [PAGE_W-1:0]         out_free_pages,
  // configuration writes
  input  wire logic                 cfg_valid,
  output logic                      cfg_ready,
  input  wire logic [CFG_IDX_W-1:0] cfg_index,
  input  wire logic [PAGE_W-1:0]    cfg_data
);

  localparam int NWORDS = (MAX_PAGES + WORD_BITS - 1) / WORD_BITS;
  localparam int AW     = (NWORDS > 1) ? $clog2(NWORDS) : 1;
  localparam logic [PAGE_W-1:0] CNT_CAP =
    (MAX_PAGES > (2**PAGE_W) - 1) ? {PAGE_W{1'b1}} : PAGE_W'(MAX_PAGES);
  localparam logic [BASE_W-1:0] WB_B     = BASE_W'(WORD_BITS);
  localparam logic [PAGE_W-1:0] BIT_MASK = PAGE_W'(WORD_BITS - 1);
  localparam logic [AW:0]       LAST_W   = (AW + 1)'(NWORDS - 1);

  // bitmap RAM
  logic [WORD_BITS-1:0] bitmap_mem [NWORDS];
  logic [WORD_BITS-1:0] mem_rd_r;
  logic                 mem_re, mem_we;
  logic [AW-1:0]        mem_ra, mem_wa;
  logic [WORD_BITS-1:0] mem_wd;

  state_t state_r, state_nxt;
  logic [AW:0]         w_r, w_nxt;
  logic [BASE_W-1:0]   b_r, b_nxt;
  logic [AW:0]         sw_r, sw_nxt;
  logic [BIT_W-1:0]    sb_r, sb_nxt;
  logic [PAGE_W-1:0]   start_r, start_nxt;
  logic                phase_r, phase_nxt;
  logic [PAGE_W-1:0]   hint_r, hint_nxt;
  logic [PAGE_W-1:0]   fc_r, fc_nxt;
  logic [IDX_W-1:0]    res_page_r, res_page_nxt;
  logic [STAT_W-1:0]   res_stat_r, res_stat_nxt;
  logic [PAGE_W-1:0]   pcount_r, resv_r;
  logic                out_valid_r, out_valid_nxt;
  logic [IDX_W-1:0]    out_page_r, out_page_nxt;
  logic [STAT_W-1:0]   out_stat_r, out_stat_nxt;
  logic [PAGE_W-1:0]   out_free_r, out_free_nxt;

  div_req_t div_req;
  div_rsp_t div_rsp;

  logic [PAGE_W-1:0]    cnt;
  logic [BASE_W-1:0]    cnt_ext, resv_ext;
  logic [BASE_W-1:0]    diff, rdiff;
  logic [WORD_BITS-1:0] page_ok, res_ok, cand, init_word, bit_sel;
  logic                 on_sw, found;
  logic [BIT_W-1:0]     fj;
  logic [BASE_W-1:0]    p, p_inc, nb;
  logic [PAGE_W-1:0]    idx_ext;

  pba_div u_div (
    .clk  (clk),
    .rst_n(rst_n),
    .req  (div_req),
    .rsp  (div_rsp)
  );

  assign cnt      = (pcount_r < CNT_CAP) ? pcount_r : CNT_CAP;
  assign cnt_ext  = {1'b0, cnt};
  assign resv_ext = {1'b0, resv_r};
  assign idx_ext  = {1'b0, in_page_index};

  // per-bit masks of the word at base b_r
  always_comb begin
    diff  = (cnt_ext > b_r) ? cnt_ext - b_r : '0;
    rdiff = (resv_ext > b_r) ? resv_ext - b_r : '0;
    on_sw = (w_r == sw_r);
    for (int j = 0; j < WORD_BITS; j++) begin
      page_ok[j]   = diff > BASE_W'(j);
      res_ok[j]    = rdiff > BASE_W'(j);
      init_word[j] = page_ok[j] ? res_ok[j] : mem_rd_r[j];
      bit_sel[j]   = (BIT_W'(j) == sb_r);
      cand[j]      = ~mem_rd_r[j] & page_ok[j] &
                     (!on_sw || (phase_r ? (BIT_W'(j) < sb_r) : (BIT_W'(j) >= sb_r)));
    end
    found = |cand;
    fj    = '0;
    for (int j = WORD_BITS - 1; j >= 0; j--) begin
      if (cand[j]) fj = BIT_W'(j);
    end
    p     = b_r + BASE_W'(fj);
    p_inc = p + BASE_W'(1);
    nb    = b_r + WB_B;
  end

  always_comb begin
    state_nxt    = state_r;
    w_nxt        = w_r;
    b_nxt        = b_r;
    sw_nxt       = sw_r;
    sb_nxt       = sb_r;
    start_nxt    = start_r;
    phase_nxt    = phase_r;
    hint_nxt     = hint_r;
    fc_nxt       = fc_r;
    res_page_nxt = res_page_r;
    res_stat_nxt = res_stat_r;
    out_valid_nxt = out_valid_r && out_stall;
    out_page_nxt = out_page_r;
    out_stat_nxt = out_stat_r;
    out_free_nxt = out_free_r;
    div_req      = '0;
    mem_re       = 1'b0;
    mem_we       = 1'b0;
    mem_ra       = w_r[AW-1:0];
    mem_wa       = w_r[AW-1:0];
    mem_wd       = '1;
    in_stall     = (state_r != S_IDLE);

    case (state_r)
      S_CLEAR: begin
        mem_we = 1'b1;
        w_nxt  = w_r + (AW + 1)'(1);
        if (w_r == LAST_W) begin
          state_nxt = S_IDLE;
        end
      end
      S_IDLE: begin
        if (in_valid) begin
          res_page_nxt = '0;
          res_stat_nxt = STAT_OK;
          state_nxt    = S_RESP;
          case (in_req_type)
            REQ_INIT: begin
              w_nxt     = '0;
              b_nxt     = '0;
              state_nxt = S_INIT_RD;
            end
            REQ_ALLOC: begin
              if (cnt == '0) begin
                res_stat_nxt = STAT_OOM;
              end else begin
                div_req.start    = 1'b1;
                div_req.dividend = hint_r;
                div_req.divisor  = cnt;
                state_nxt        = S_DIV_HINT;
              end
            end
            REQ_FREE: begin
              if (idx_ext >= cnt) begin
                res_stat_nxt = STAT_RANGE;
              end else begin
                start_nxt = idx_ext;
                sb_nxt    = in_page_index[BIT_W-1:0];
                w_nxt     = (AW + 1)'(idx_ext >> BIT_W);
                state_nxt = S_FREE_RD;
              end
            end
            default: begin
              // unused code: report the current count, change nothing
            end
          endcase
        end
      end
      S_INIT_RD: begin
        if (b_r >= cnt_ext) begin
          if (resv_r < cnt) begin
            fc_nxt   = cnt - resv_r;
            hint_nxt = resv_r;
          end else begin
            fc_nxt   = '0;
            hint_nxt = '0;
          end
          state_nxt = S_RESP;
        end else begin
          mem_re    = 1'b1;
          state_nxt = S_INIT_WR;
        end
      end
      S_INIT_WR: begin
        mem_we    = 1'b1;
        mem_wd    = init_word;
        w_nxt     = w_r + (AW + 1)'(1);
        b_nxt     = nb;
        state_nxt = S_INIT_RD;
      end
      S_DIV_HINT: begin
        // split the start page into word and bit
        if (div_rsp.done) begin
          sb_nxt    = div_rsp.rem[BIT_W-1:0];
          sw_nxt    = (AW + 1)'(div_rsp.rem >> BIT_W);
          w_nxt     = (AW + 1)'(div_rsp.rem >> BIT_W);
          b_nxt     = {1'b0, div_rsp.rem & ~BIT_MASK};
          phase_nxt = 1'b0;
          state_nxt = S_SCAN_RD;
        end
      end
      S_SCAN_RD: begin
        mem_re    = 1'b1;
        state_nxt = S_SCAN_CHK;
      end
      S_SCAN_CHK: begin
        if (found) begin
          mem_we = 1'b1;
          for (int j = 0; j < WORD_BITS; j++) begin
            mem_wd[j] = mem_rd_r[j] | (BIT_W'(j) == fj);
          end
          hint_nxt     = (p_inc == cnt_ext) ? '0 : p_inc[PAGE_W-1:0];
          if (fc_r != '0) fc_nxt = fc_r - PAGE_W'(1);
          res_page_nxt = p[IDX_W-1:0];
          res_stat_nxt = STAT_OK;
          state_nxt    = S_RESP;
        end else if (phase_r && on_sw) begin
          res_stat_nxt = STAT_OOM;
          state_nxt    = S_RESP;
        end else if (!phase_r && nb >= cnt_ext) begin
          // wrap to the bottom of the bitmap
          w_nxt     = '0;
          b_nxt     = '0;
          phase_nxt = 1'b1;
          state_nxt = S_SCAN_RD;
        end else begin
          w_nxt     = w_r + (AW + 1)'(1);
          b_nxt     = nb;
          state_nxt = S_SCAN_RD;
        end
      end
      S_FREE_RD: begin
        mem_re    = 1'b1;
        state_nxt = S_FREE_WR;
      end
      S_FREE_WR: begin
        mem_we = 1'b1;
        mem_wd = mem_rd_r & ~bit_sel;
        if (fc_r < cnt) fc_nxt = fc_r + PAGE_W'(1);
        if (start_r < hint_r) hint_nxt = start_r;
        state_nxt = S_RESP;
      end
      S_RESP: begin
        // hold until the output register is free
        if (!out_valid_r || !out_stall) begin
          out_valid_nxt = 1'b1;
          out_page_nxt  = res_page_r;
          out_stat_nxt  = res_stat_r;
          out_free_nxt  = fc_r;
          state_nxt     = S_IDLE;
        end
      end
      default: begin
        state_nxt = S_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (mem_we) begin
      bitmap_mem[mem_wa] <= mem_wd;
    end
    if (mem_re) begin
      mem_rd_r <= bitmap_mem[mem_ra];
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= S_CLEAR;
      w_r         <= '0;
      hint_r      <= '0;
      fc_r        <= '0;
      out_valid_r <= 1'b0;
      pcount_r    <= PAGE_W'(65536);
      resv_r      <= PAGE_W'(256);
    end else begin
      state_r     <= state_nxt;
      w_r         <= w_nxt;
      hint_r      <= hint_nxt;
      fc_r        <= fc_nxt;
      out_valid_r <= out_valid_nxt;
      if (cfg_valid && cfg_ready) begin
        case (cfg_index)
          CFG_PAGE_COUNT: pcount_r <= cfg_data;
          CFG_RESERVED:   resv_r   <= cfg_data;
          default: begin
          end
        endcase
      end
    end
    b_r        <= b_nxt;
    sw_r       <= sw_nxt;
    sb_r       <= sb_nxt;
    start_r    <= start_nxt;
    phase_r    <= phase_nxt;
    res_page_r <= res_page_nxt;
    res_stat_r <= res_stat_nxt;
    out_page_r <= out_page_nxt;
    out_stat_r <= out_stat_nxt;
    out_free_r <= out_free_nxt;
  end

  assign cfg_ready          = 1'b1;
  assign out_valid          = out_valid_r;
  assign out_page_index_out = out_page_r;
  assign out_status         = out_stat_r;
  assign out_free_pages     = out_free_r;

endmodule

`default_nettype wire
